FILE: sv/cpp_pkg.sv
// ----------------------------------------------------------------------------
// cpp_pkg
// Shared constants and types for the camera perspective projection block.
// ----------------------------------------------------------------------------
package cpp_pkg;

    localparam int DEF_SCREEN_WIDTH  = 640;
    localparam int DEF_SCREEN_HEIGHT = 480;

    localparam int REG_IDX_W = 3;
    localparam int CFG_W     = 36;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_YAW    = 3'd0,
        REG_PITCH  = 3'd1,
        REG_ROLL   = 3'd2,
        REG_ORG_X  = 3'd3,
        REG_ORG_Y  = 3'd4,
        REG_ORG_Z  = 3'd5,
        REG_AHEAD  = 3'd6,
        REG_ZOOM   = 3'd7
    } reg_idx_t;

    // quotient bits produced by each divider stage
    localparam int DIV_STEP = 4;

    // divider operand widths: screen numerators are |x*zoom| (below 2^63),
    // a whole number of divider stages
    localparam int NUM_W = 64;
    localparam int DEN_W = 32;

    // per-stage control record holding a valid bit
    typedef struct packed {
        logic valid;
    } pipe_ctl_t;

    function automatic logic signed [33:0] floor_q16(input logic signed [50:0] v);
        floor_q16 = v[49:16];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        if (v > 38'sh00_7FFF_FFFF)
            sat32 = 32'sh7FFF_FFFF;
        else if (v < -38'sh00_8000_0000)
            sat32 = 32'sh8000_0000;
        else
            sat32 = v[31:0];
    endfunction

endpackage

FILE: sv/camera_perspective_projection.sv
// ----------------------------------------------------------------------------
// camera_perspective_projection
// World point to screen pixel and inverse depth, fully pipelined.
// ----------------------------------------------------------------------------
// Accepts one point per clock unless the skid stage is full and returns one
// word per point in order, through 6 front stages (translate, yaw, pitch, roll
// with the ahead offset, saturation, zoom multiply), 16 stages of the radix-16
// divider and 2 output stages; the divider depth, set by the 64 bit numerator,
// dominates. A full pipeline with a stalled output freezes in place, and an
// output skid register lets the next word be taken while the last one waits.
module camera_perspective_projection #(
    parameter int SCREEN_WIDTH  = cpp_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = cpp_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [cpp_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [cpp_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [31:0]            point_x,
    input  logic signed [31:0]            point_y,
    input  logic signed [31:0]            point_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [15:0]            screen_x,
    output logic signed [15:0]            screen_y,
    output logic signed [31:0]            inverse_depth,
    output logic                          zero_depth
);
    import cpp_pkg::*;

    localparam logic signed [63:0] CX = 64'(SCREEN_WIDTH / 2) <<< 16;
    localparam logic signed [63:0] CY = 64'(SCREEN_HEIGHT / 2) <<< 16;

    // configuration
    logic [35:0]        yaw_reg, pitch_reg, roll_reg;
    logic signed [31:0] org_x_reg, org_y_reg, org_z_reg, ahead_reg;
    logic [31:0]        zoom_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yaw_reg   <= 36'h4_0000_0000;
            pitch_reg <= 36'h4_0000_0000;
            roll_reg  <= 36'h4_0000_0000;
            org_x_reg <= '0;
            org_y_reg <= '0;
            org_z_reg <= '0;
            ahead_reg <= '0;
            zoom_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_YAW:   yaw_reg   <= cfg_data;
                REG_PITCH: pitch_reg <= cfg_data;
                REG_ROLL:  roll_reg  <= cfg_data;
                REG_ORG_X: org_x_reg <= cfg_data[31:0];
                REG_ORG_Y: org_y_reg <= cfg_data[31:0];
                REG_ORG_Z: org_z_reg <= cfg_data[31:0];
                REG_AHEAD: ahead_reg <= cfg_data[31:0];
                REG_ZOOM:  zoom_reg  <= cfg_data[31:0];
                default:   ;
            endcase
        end
    end

    logic signed [17:0] yc, ys, pc, ps, rc, rs;
    assign yc = yaw_reg[35:18];
    assign ys = yaw_reg[17:0];
    assign pc = pitch_reg[35:18];
    assign ps = pitch_reg[17:0];
    assign rc = roll_reg[35:18];
    assign rs = roll_reg[17:0];

    // global pipeline enable: stall only when the skid stage is full
    logic en;
    logic skid_full_reg;
    assign en       = !skid_full_reg;
    assign in_ready = en;

    // stage 1: translate (33 bit)
    logic               v1_reg;
    logic signed [32:0] x1_reg, y1_reg, z1_reg;
    // stage 2: yaw, x and z (36 bit after floor)
    logic               v2_reg;
    logic signed [35:0] x2_reg, z2_reg;
    logic signed [32:0] y2_reg;
    // stage 3: pitch (37 bit)
    logic               v3_reg;
    logic signed [35:0] x3_reg;
    logic signed [36:0] y3_reg, z3_reg;
    // stage 4: roll, offset (38 bit)
    logic               v4_reg;
    logic signed [37:0] x4_reg, y4_reg, z4_reg;
    // stage 5: saturate
    logic               v5_reg;
    logic signed [31:0] x5_reg, y5_reg, z5_reg;
    // stage 6: zoom products and divider operands
    logic               v6_reg;
    logic signed [63:0] px6_reg, py6_reg;
    logic signed [31:0] z6_reg;

    // 38 by 18 product pairs; sums stay within 55 bits
    function automatic logic signed [54:0] mac2(input logic signed [37:0] a,
                                               input logic signed [17:0] b,
                                               input logic signed [37:0] c,
                                               input logic signed [17:0] d,
                                               input logic               sub);
        logic signed [54:0] p, q;
        p = 55'(a) * 55'(b);
        q = 55'(c) * 55'(d);
        mac2 = sub ? p - q : p + q;
    endfunction

    function automatic logic signed [38:0] fl(input logic signed [54:0] v);
        fl = v[54:16];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    logic signed [38:0] yaw_x, yaw_z, pit_y, pit_z, rol_x, rol_y;
    assign yaw_x = fl(mac2(38'(x1_reg), yc, 38'(z1_reg), ys, 1'b0));
    assign yaw_z = fl(mac2(38'(z1_reg), yc, 38'(x1_reg), ys, 1'b1));
    assign pit_y = fl(mac2(38'(z2_reg), ps, 38'(y2_reg), pc, 1'b1));
    assign pit_z = fl(mac2(38'(z2_reg), pc, 38'(y2_reg), ps, 1'b0));
    assign rol_x = fl(mac2(38'(x3_reg), rc, 38'(y3_reg), rs, 1'b0));
    assign rol_y = fl(mac2(38'(y3_reg), rc, 38'(x3_reg), rs, 1'b1));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg  <= 33'(point_x) - 33'(org_x_reg);
            y1_reg  <= 33'(point_y) - 33'(org_y_reg);
            z1_reg  <= 33'(point_z) - 33'(org_z_reg);
            x2_reg  <= yaw_x[35:0];
            z2_reg  <= yaw_z[35:0];
            y2_reg  <= y1_reg;
            x3_reg  <= x2_reg;
            y3_reg  <= pit_y[36:0];
            z3_reg  <= pit_z[36:0];
            x4_reg  <= rol_x[37:0];
            y4_reg  <= rol_y[37:0];
            z4_reg  <= 38'(z3_reg) + 38'(ahead_reg);
            x5_reg  <= sat32(x4_reg);
            y5_reg  <= sat32(y4_reg);
            z5_reg  <= sat32(z4_reg);
            px6_reg <= 64'(x5_reg) * 64'($signed({1'b0, zoom_reg}));
            py6_reg <= 64'(y5_reg) * 64'($signed({1'b0, zoom_reg}));
            z6_reg  <= z5_reg;
        end
    end

    // magnitudes for the three unsigned dividers
    logic             zneg, xneg, yneg, zzero;
    logic [31:0]      zmag;
    logic [NUM_W-1:0] xmag, ymag, imag;
    assign zneg  = z6_reg[31];
    assign zzero = (z6_reg == '0);
    assign xneg  = px6_reg[63] ^ zneg;
    assign yneg  = py6_reg[63] ^ zneg;
    assign zmag  = zneg ? 32'(-33'(z6_reg)) : 32'(z6_reg);
    assign xmag  = px6_reg[63] ? 64'(-px6_reg) : 64'(px6_reg);
    assign ymag  = py6_reg[63] ? 64'(-py6_reg) : 64'(py6_reg);
    assign imag  = 64'h1_0000_0000;

    localparam int SIDE_W = 4;
    logic [SIDE_W-1:0] side_in, side_x, side_y, side_i;
    logic              dv_x, dv_y, dv_i;
    logic [NUM_W-1:0]  qx, qy, qi;
    assign side_in = {zzero, zneg, yneg, xneg};

    cpp_divider #(.N_W(NUM_W), .D_W(DEN_W), .P_W(SIDE_W)) u_div_x (
        .clk, .rst_n, .en, .in_valid(v6_reg), .in_num(xmag), .in_den(zmag),
        .in_side(side_in), .out_valid(dv_x), .out_quo(qx), .out_side(side_x));
    cpp_divider #(.N_W(NUM_W), .D_W(DEN_W), .P_W(SIDE_W)) u_div_y (
        .clk, .rst_n, .en, .in_valid(v6_reg), .in_num(ymag), .in_den(zmag),
        .in_side(side_in), .out_valid(dv_y), .out_quo(qy), .out_side(side_y));
    cpp_divider #(.N_W(NUM_W), .D_W(DEN_W), .P_W(SIDE_W)) u_div_i (
        .clk, .rst_n, .en, .in_valid(v6_reg), .in_num(imag), .in_den(zmag),
        .in_side(side_in), .out_valid(dv_i), .out_quo(qi), .out_side(side_i));

    // stage 7: clamp magnitudes to 2^40 and to the inverse range, add center
    localparam logic [NUM_W-1:0] LIM = 64'h100_0000_0000;
    logic [40:0] cx_mag, cy_mag;
    assign cx_mag = (qx > LIM) ? 41'(LIM) : qx[40:0];
    assign cy_mag = (qy > LIM) ? 41'(LIM) : qy[40:0];

    logic               v7_reg, z7_reg;
    logic signed [43:0] tx7_reg, ty7_reg;
    logic signed [31:0] inv7_reg;
    logic signed [33:0] inv_s;
    // inverse depth takes the sign of the depth alone
    assign inv_s = side_i[2] ? -34'(qi[32:0]) : 34'(qi[32:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v7_reg <= 1'b0;
        else if (en)
            v7_reg <= dv_x;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tx7_reg  <= (side_x[0] ? -44'(cx_mag) : 44'(cx_mag)) + 44'(CX) + 44'sd32768;
            ty7_reg  <= (side_y[1] ? -44'(cy_mag) : 44'(cy_mag)) + 44'(CY) + 44'sd32768;
            z7_reg   <= side_x[3];
            if (inv_s > 34'sh0_7FFF_FFFF)
                inv7_reg <= 32'sh7FFF_FFFF;
            else if (inv_s < -34'sh0_8000_0000)
                inv7_reg <= 32'sh8000_0000;
            else
                inv7_reg <= inv_s[31:0];
        end
    end

    // truncate toward zero then saturate to 16 bits
    function automatic logic signed [15:0] pix(input logic signed [43:0] t);
        logic signed [43:0] m;
        logic signed [27:0] q;
        m = t[43] ? -t : t;
        q = t[43] ? -28'(m[43:16]) : 28'(m[43:16]);
        if (q > 28'sd32767)
            pix = 16'sh7FFF;
        else if (q < -28'sd32768)
            pix = 16'sh8000;
        else
            pix = q[15:0];
    endfunction

    // stage 8: output register with one-deep skid
    logic               ov_reg;
    logic signed [15:0] sx_reg, sy_reg, sx_skid_reg, sy_skid_reg;
    logic signed [31:0] inv_reg, inv_skid_reg;
    logic               zd_reg, zd_skid_reg;
    logic signed [15:0] sx_next, sy_next;
    logic signed [31:0] inv_next;

    assign sx_next  = z7_reg ? '0 : pix(tx7_reg);
    assign sy_next  = z7_reg ? '0 : pix(ty7_reg);
    assign inv_next = z7_reg ? '0 : inv7_reg;

    logic out_take;
    assign out_take = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg        <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            if (skid_full_reg)
            begin
                if (out_take)
                begin
                    ov_reg        <= 1'b1;
                    skid_full_reg <= 1'b0;
                end
            end
            else if (!ov_reg || out_take)
                ov_reg <= v7_reg;
            else if (v7_reg)
                skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_full_reg)
        begin
            if (out_take)
            begin
                sx_reg  <= sx_skid_reg;
                sy_reg  <= sy_skid_reg;
                inv_reg <= inv_skid_reg;
                zd_reg  <= zd_skid_reg;
            end
        end
        else if (!ov_reg || out_take)
        begin
            sx_reg  <= sx_next;
            sy_reg  <= sy_next;
            inv_reg <= inv_next;
            zd_reg  <= z7_reg;
        end
        else
        begin
            sx_skid_reg  <= sx_next;
            sy_skid_reg  <= sy_next;
            inv_skid_reg <= inv_next;
            zd_skid_reg  <= z7_reg;
        end
    end

    assign out_valid     = ov_reg;
    assign screen_x      = sx_reg;
    assign screen_y      = sy_reg;
    assign inverse_depth = inv_reg;
    assign zero_depth    = zd_reg;

    // the three dividers run in lockstep
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_x == dv_y) && (dv_x == dv_i))
        else $error("divider valid mismatch");

    // zero depth word carries zero payload
    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && zero_depth) |-> (screen_x == 0 && screen_y == 0 && inverse_depth == 0))
        else $error("zero depth word with nonzero payload");

    // skid fills only when the output word is held
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_full_reg) |-> $past(out_valid && !out_ready))
        else $error("skid filled while output free");

endmodule

FILE: sv/cpp_divider.sv
// ----------------------------------------------------------------------------
// cpp_divider
// Pipelined unsigned restoring divider, DIV_STEP quotient bits per stage,
// with a side payload carried along.
// ----------------------------------------------------------------------------
module cpp_divider #(
    parameter int N_W = 64,
    parameter int D_W = 32,
    parameter int P_W = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  logic [N_W-1:0] in_num,
    input  logic [D_W-1:0] in_den,
    input  logic [P_W-1:0] in_side,
    output logic           out_valid,
    output logic [N_W-1:0] out_quo,
    output logic [P_W-1:0] out_side
);
    import cpp_pkg::*;

    localparam int STAGES = (N_W + DIV_STEP - 1) / DIV_STEP;
    localparam int R_W    = D_W + 1;

    logic [N_W-1:0] num_reg  [STAGES+1];
    logic [R_W-1:0] rem_reg  [STAGES+1];
    logic [D_W-1:0] den_reg  [STAGES+1];
    logic [P_W-1:0] side_reg [STAGES+1];
    logic           vld_reg  [STAGES+1];

    assign num_reg[0]  = in_num;
    assign rem_reg[0]  = '0;
    assign den_reg[0]  = in_den;
    assign side_reg[0] = in_side;
    assign vld_reg[0]  = in_valid;

    genvar s;
    generate
        for (s = 0; s < STAGES; s++)
        begin : g_stage
            logic [N_W-1:0] num_next;
            logic [R_W-1:0] rem_next;
            logic [N_W-1:0] num_q;
            logic [R_W-1:0] rem_q;
            logic [D_W-1:0] den_q;
            logic [P_W-1:0] side_q;
            logic           vld_q;

            // shift in one numerator bit per step, quotient bit replaces it
            always_comb
            begin
                logic [R_W-1:0] r;
                logic [N_W-1:0] n;
                r = rem_reg[s];
                n = num_reg[s];
                for (int k = 0; k < DIV_STEP; k++)
                begin
                    r = {r[R_W-2:0], n[N_W-1]};
                    n = {n[N_W-2:0], 1'b0};
                    if (r >= {1'b0, den_reg[s]})
                    begin
                        r    = r - {1'b0, den_reg[s]};
                        n[0] = 1'b1;
                    end
                end
                num_next = n;
                rem_next = r;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_q <= 1'b0;
                else if (en)
                    vld_q <= vld_reg[s];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    num_q  <= num_next;
                    rem_q  <= rem_next;
                    den_q  <= den_reg[s];
                    side_q <= side_reg[s];
                end
            end

            assign num_reg[s+1]  = num_q;
            assign rem_reg[s+1]  = rem_q;
            assign den_reg[s+1]  = den_q;
            assign side_reg[s+1] = side_q;
            assign vld_reg[s+1]  = vld_q;
        end
    endgenerate

    assign out_valid = vld_reg[STAGES];
    assign out_quo   = num_reg[STAGES];
    assign out_side  = side_reg[STAGES];

endmodule
